### src/idalloc_pkg.sv
// ----------------------------------------------------------------------------
// idalloc_pkg
// Types and codes shared by the handle allocator and its free stack cells.
// ----------------------------------------------------------------------------
package idalloc_pkg;

    localparam int HANDLE_W = 11;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_CHECK   = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef logic [HANDLE_W-1:0] handle_t;

    typedef struct packed {
        logic [1:0] mode;
        handle_t    handle_in;
    } req_item_t;

    typedef struct packed {
        handle_t    handle_out;
        logic [1:0] status;
        logic       is_live;
        handle_t    live_count;
    } rsp_item_t;

    typedef struct packed {
        logic    push;
        logic    pop;
        handle_t data;
    } stk_ctl_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

### src/idalloc_cell.sv
// ----------------------------------------------------------------------------
// idalloc_cell
// One entry of the free stack; shifts down on push, up on pop.
// ----------------------------------------------------------------------------
module idalloc_cell (
    input  logic                 clk,
    input  idalloc_pkg::stk_ctl_t ctl,
    input  idalloc_pkg::handle_t  up,
    input  idalloc_pkg::handle_t  dn,
    output idalloc_pkg::handle_t  q
);
    import idalloc_pkg::*;

    handle_t q_reg;
    handle_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctl.push)
        begin
            q_next = up;
        end
        else if (ctl.pop)
        begin
            q_next = dn;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

### src/idalloc_stack.sv
// ----------------------------------------------------------------------------
// idalloc_stack
// Free stack as a chain of cells; cell 0 is the top of the stack.
// ----------------------------------------------------------------------------
module idalloc_stack #(
    parameter int DEPTH = 1024
) (
    input  logic                  clk,
    input  idalloc_pkg::stk_ctl_t ctl,
    output idalloc_pkg::handle_t  top
);
    import idalloc_pkg::*;

    handle_t cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        handle_t up_d;
        handle_t dn_d;

        if (i == 0)
        begin : g_first
            assign up_d = ctl.data;
        end
        else
        begin : g_mid_up
            assign up_d = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign dn_d = '0;
        end
        else
        begin : g_mid_dn
            assign dn_d = cell_q[i+1];
        end

        idalloc_cell u_cell (
            .clk (clk),
            .ctl (ctl),
            .up  (up_d),
            .dn  (dn_d),
            .q   (cell_q[i])
        );
    end

    assign top = cell_q[0];

endmodule

### src/id_allocator_with_free_stack.sv
// ----------------------------------------------------------------------------
// id_allocator_with_free_stack
// Each accepted request is held in item_reg while the live bitmap is read,
// then the bitmap and free stack take a read-modify-write and the response is
// registered; no new request is taken until that is done, and a response left
// waiting holds off the next item until it is taken.
// Reset: counts cleared, no response pending; bitmap and stack need no clear.
// ----------------------------------------------------------------------------
module id_allocator_with_free_stack #(
    parameter int MAX_HANDLES = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  idalloc_pkg::req_item_t req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output idalloc_pkg::rsp_item_t rsp
);
    import idalloc_pkg::*;

    localparam int CNT_W = $clog2(MAX_HANDLES + 1);
    localparam int CMP_W = (CNT_W + 1 > HANDLE_W) ? CNT_W + 1 : HANDLE_W;

    state_t    state_reg;
    state_t    state_next;
    req_item_t item_reg;
    rsp_item_t rsp_reg;
    rsp_item_t rsp_next;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    logic [CNT_W-1:0] live_reg;
    logic [CNT_W-1:0] live_next;
    logic [CNT_W-1:0] free_reg;
    logic [CNT_W-1:0] free_next;

    logic             bm_mem [0:MAX_HANDLES];
    logic             bm_rd_reg;
    logic [CNT_W-1:0] bm_rd_addr;
    logic             bm_wr_en;
    logic [CNT_W-1:0] bm_wr_addr;
    logic             bm_wr_data;

    stk_ctl_t   stk_ctl;
    handle_t    stk_top;
    logic       finish;
    logic       in_range;
    logic       hit;
    logic [CMP_W-1:0] issued;
    logic [CMP_W-1:0] h_ext;

    idalloc_stack #(.DEPTH(MAX_HANDLES)) u_stack (
        .clk (clk),
        .ctl (stk_ctl),
        .top (stk_top)
    );

    assign bm_rd_addr = (state_reg == S_IDLE) ? CNT_W'(req.handle_in)
                                              : CNT_W'(item_reg.handle_in);

    always_ff @(posedge clk)
    begin
        if (bm_wr_en)
        begin
            bm_mem[bm_wr_addr] <= bm_wr_data;
        end
        bm_rd_reg <= bm_mem[bm_rd_addr];
    end

    assign issued   = CMP_W'(live_reg) + CMP_W'(free_reg);
    assign h_ext    = CMP_W'(item_reg.handle_in);
    assign in_range = (item_reg.handle_in != '0) && (h_ext <= issued)
                      && (h_ext <= CMP_W'(MAX_HANDLES));
    assign hit      = in_range && bm_rd_reg;
    assign finish   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next     = state_reg;
        live_next      = live_reg;
        free_next      = free_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        bm_wr_en       = 1'b0;
        bm_wr_addr     = CNT_W'(item_reg.handle_in);
        bm_wr_data     = 1'b0;
        stk_ctl.push   = 1'b0;
        stk_ctl.pop    = 1'b0;
        stk_ctl.data   = item_reg.handle_in;

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    rsp_next            = '0;
                    state_next          = S_IDLE;
                    rsp_valid_next      = 1'b1;
                    case (item_reg.mode)
                        MODE_ALLOC:
                        begin
                            if (free_reg != '0)
                            begin
                                stk_ctl.pop         = 1'b1;
                                free_next           = free_reg - 1'b1;
                                live_next           = live_reg + 1'b1;
                                rsp_next.handle_out = stk_top;
                                bm_wr_en            = 1'b1;
                                bm_wr_addr          = CNT_W'(stk_top);
                                bm_wr_data          = 1'b1;
                            end
                            else if (live_reg < CNT_W'(MAX_HANDLES))
                            begin
                                live_next           = live_reg + 1'b1;
                                rsp_next.handle_out = HANDLE_W'(live_reg + 1'b1);
                                bm_wr_en            = 1'b1;
                                bm_wr_addr          = live_reg + 1'b1;
                                bm_wr_data          = 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            if (hit && (free_reg < CNT_W'(MAX_HANDLES)))
                            begin
                                stk_ctl.push = 1'b1;
                                free_next    = free_reg + 1'b1;
                                live_next    = live_reg - 1'b1;
                                bm_wr_en     = 1'b1;
                                bm_wr_data   = 1'b0;
                            end
                            else
                            begin
                                rsp_next.status = STAT_NOT_FOUND;
                            end
                        end
                        MODE_CHECK:
                        begin
                            rsp_next.is_live = hit;
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.live_count = HANDLE_W'(live_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            live_reg      <= '0;
            free_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            live_reg      <= live_next;
            free_reg      <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### src/idalloc_chk.sv
// ----------------------------------------------------------------------------
// idalloc_chk
// Port-level checks for the handle allocator, bound to the top level.
// ----------------------------------------------------------------------------
module idalloc_chk #(
    parameter int MAX_HANDLES = 1024
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input idalloc_pkg::req_item_t req,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input idalloc_pkg::rsp_item_t rsp
);
    import idalloc_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous item in flight");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_FULL)
        |-> rsp.live_count == HANDLE_W'(MAX_HANDLES))
        else $error("full reported below capacity");

    a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.handle_out != '0)
        |-> (rsp.status == STAT_OK) && !rsp.is_live && (rsp.live_count != '0))
        else $error("allocated handle with inconsistent result");

    a_live_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_live
        |-> (rsp.status == STAT_OK) && (rsp.handle_out == '0)
            && (rsp.live_count != '0))
        else $error("live check with inconsistent result");

endmodule

bind id_allocator_with_free_stack idalloc_chk #(.MAX_HANDLES(MAX_HANDLES)) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the handle allocator with its LIFO free stack.
// A local predictor tracks live flags, the free stack and both counts, and
// works out the response of every accepted request. Directed cases cover
// the empty and full extremes, bad releases, out-of-range checks and the
// unused mode. Random phases mix requests, fill the allocator to capacity
// and drain it again; both handshakes stall at random except in the drain phase.
// ----------------------------------------------------------------------------
module tb;
    import idalloc_pkg::*;

    localparam int MAX_HANDLES = 1024;
    localparam logic [1:0] MODE_NONE = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    bit        live_map [1:MAX_HANDLES];
    handle_t   free_lifo [MAX_HANDLES];
    int        live_cnt = 0;
    int        free_cnt = 0;

    rsp_item_t pending_rsp_q [$];
    rsp_item_t want_rsp;
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    id_allocator_with_free_stack #(
        .MAX_HANDLES (MAX_HANDLES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bit handle_live(input handle_t h);
        if (h == 0 || h > live_cnt + free_cnt || h > MAX_HANDLES)
            return 1'b0;
        return live_map[h];
    endfunction

    // Applies one request to the local allocator state, returns its response.
    function automatic rsp_item_t predict_alloc_rsp(input req_item_t it);
        rsp_item_t r;
        handle_t   h;
        r = '0;
        h = it.handle_in;
        case (it.mode)
            MODE_ALLOC:
            begin
                if (free_cnt > 0)
                begin
                    free_cnt--;
                    r.handle_out = free_lifo[free_cnt];
                    live_map[r.handle_out] = 1'b1;
                    live_cnt++;
                end
                else if (live_cnt < MAX_HANDLES)
                begin
                    r.handle_out = handle_t'(live_cnt + 1);
                    live_map[live_cnt + 1] = 1'b1;
                    live_cnt++;
                end
                else
                    r.status = STAT_FULL;
            end
            MODE_RELEASE:
            begin
                if (handle_live(h) && free_cnt < MAX_HANDLES)
                begin
                    live_map[h] = 1'b0;
                    free_lifo[free_cnt] = h;
                    free_cnt++;
                    live_cnt--;
                end
                else
                    r.status = STAT_NOT_FOUND;
            end
            MODE_CHECK:
                r.is_live = handle_live(h);
            default:
                ;
        endcase
        r.live_count = handle_t'(live_cnt);
        return r;
    endfunction

    // Random live handle, or 0 when nothing is live.
    function automatic int pick_live();
        int issued;
        int h;
        issued = live_cnt + free_cnt;
        if (live_cnt == 0)
            return 0;
        h = $urandom_range(1, issued);
        while (!live_map[h])
            h = (h == issued) ? 1 : h + 1;
        return h;
    endfunction

    task automatic log_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask

    // Called right after a rising edge; returns right after one.
    task automatic send_req(input logic [1:0] mode, input int h);
        req_item_t it;
        it.mode = mode;
        it.handle_in = handle_t'(h);
        req <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rsp_q.push_back(predict_alloc_rsp(it));
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    // Weights in percent; whatever is left goes to the unused mode.
    task automatic send_random(input int w_alloc, input int w_rel_live,
                               input int w_rel_any, input int w_check);
        int roll;
        int issued;
        int sel;
        roll = $urandom_range(0, 99);
        issued = live_cnt + free_cnt;
        if (roll < w_alloc)
            send_req(MODE_ALLOC, $urandom_range(0, 2047));
        else if (roll < w_alloc + w_rel_live)
            send_req(MODE_RELEASE, pick_live());
        else if (roll < w_alloc + w_rel_live + w_rel_any)
        begin
            if ($urandom_range(0, 1))
                send_req(MODE_RELEASE, $urandom_range(0, 2047));
            else
                send_req(MODE_RELEASE, $urandom_range(0, issued + 2));
        end
        else if (roll < w_alloc + w_rel_live + w_rel_any + w_check)
        begin
            sel = $urandom_range(0, 3);
            if (sel < 2)
                send_req(MODE_CHECK, pick_live());
            else if (sel == 2)
                send_req(MODE_CHECK, $urandom_range(0, issued + 1));
            else
                send_req(MODE_CHECK, $urandom_range(0, 2047));
        end
        else
            send_req(MODE_NONE, $urandom_range(0, 2047));
    endtask

    task automatic test_directed_cases();
        send_req(MODE_CHECK, 0);
        send_req(MODE_CHECK, 1);
        send_req(MODE_RELEASE, 0);
        send_req(MODE_RELEASE, 1);
        send_req(MODE_RELEASE, 2047);
        send_req(MODE_CHECK, 2047);
        send_req(MODE_NONE, 2047);
        send_req(MODE_ALLOC, 2047);
        send_req(MODE_ALLOC, 0);
        send_req(MODE_ALLOC, 0);
        send_req(MODE_CHECK, 2);
        send_req(MODE_RELEASE, 2);
        send_req(MODE_RELEASE, 2);
        send_req(MODE_CHECK, 2);
        send_req(MODE_ALLOC, 0);
        send_req(MODE_RELEASE, 3);
        send_req(MODE_RELEASE, 1);
        send_req(MODE_ALLOC, 0);
        send_req(MODE_ALLOC, 0);
        send_req(MODE_ALLOC, 0);
        send_req(MODE_CHECK, 1024);
        send_req(MODE_RELEASE, 1024);
        send_req(MODE_NONE, 0);
        send_req(MODE_CHECK, 4);
    endtask

    task automatic test_random_mix();
        repeat (150)
            send_random(40, 30, 10, 15);
    endtask

    task automatic test_fill_to_full();
        int h;
        while (live_cnt < MAX_HANDLES)
            send_random(93, 3, 1, 3);
        repeat (4)
            send_req(MODE_ALLOC, $urandom_range(0, 2047));
        send_req(MODE_CHECK, 1024);
        send_req(MODE_CHECK, 1025);
        send_req(MODE_RELEASE, 1025);
        h = pick_live();
        send_req(MODE_RELEASE, h);
        send_req(MODE_CHECK, h);
        send_req(MODE_ALLOC, 0);
        send_req(MODE_ALLOC, 0);
        send_req(MODE_RELEASE, 1024);
        send_req(MODE_RELEASE, 1024);
        send_req(MODE_ALLOC, 0);
        send_req(MODE_ALLOC, 0);
        send_req(MODE_NONE, 1024);
    endtask

    task automatic test_drain_and_reuse();
        repeat (200)
            send_random(15, 60, 8, 12);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp_q.size() == 0)
                log_mismatch("item with nothing pending", 1, 0);
            else
            begin
                want_rsp = pending_rsp_q.pop_front();
                if (rsp.handle_out !== want_rsp.handle_out)
                    log_mismatch("handle_out", rsp.handle_out, want_rsp.handle_out);
                if (rsp.status !== want_rsp.status)
                    log_mismatch("status", rsp.status, want_rsp.status);
                if (rsp.is_live !== want_rsp.is_live)
                    log_mismatch("is_live", rsp.is_live, want_rsp.is_live);
                if (rsp.live_count !== want_rsp.live_count)
                    log_mismatch("live_count", rsp.live_count, want_rsp.live_count);
            end
        end
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 57;
        test_directed_cases();
        test_random_mix();

        send_idle_pct = 57;
        recv_idle_pct = 24;
        test_fill_to_full();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_drain_and_reuse();

        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
